### design/gea_pkg.sv
package gea_pkg;

  localparam int DIR_KEYS   = 4;
  localparam int BUTTONS_IN = 16;
  localparam int KEY_BITS   = 20;

  localparam int AXIS_W   = 11;
  localparam int ANGLE_W  = 16;
  localparam int DELAY_W  = 7;
  localparam int THRESH_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Sector borders in hundredths of a degree; every border is inclusive.
  localparam logic [ANGLE_W-1:0] ANGLE_UP_RIGHT   = 16'd4500;
  localparam logic [ANGLE_W-1:0] ANGLE_RIGHT_DOWN = 16'd13500;
  localparam logic [ANGLE_W-1:0] ANGLE_DOWN_LEFT  = 16'd22500;
  localparam logic [ANGLE_W-1:0] ANGLE_LEFT_UP    = 16'd31500;

  localparam logic [DELAY_W-1:0]  FIRST_DELAY_RST   = 7'd20;
  localparam logic [DELAY_W-1:0]  REPEAT_PERIOD_RST = 7'd5;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST     = 10'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DELAY     = 2'd0,
    CFG_REPEAT_PERIOD   = 2'd1,
    CFG_STICK_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Direction keys in output bit order: up is bit 0.
  typedef struct packed {
    logic left;
    logic down;
    logic right;
    logic up;
  } dir_keys_t;

endpackage

### design/gea_ifs.sv
interface gea_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gea_pkg::AXIS_W-1:0]    stick_x;
  logic signed [gea_pkg::AXIS_W-1:0]    stick_y;
  logic        [gea_pkg::ANGLE_W-1:0]   hat_angle;
  logic                                 hat_centered;
  logic        [gea_pkg::BUTTONS_IN-1:0] button_bits;

  modport source (output valid, stick_x, stick_y, hat_angle, hat_centered, button_bits,
                  input ready);
  modport sink (input valid, stick_x, stick_y, hat_angle, hat_centered, button_bits,
                output ready);
endinterface

interface gea_out_if;
  logic                             valid;
  logic                             ready;
  logic [gea_pkg::KEY_BITS-1:0]     held_keys;
  logic [gea_pkg::KEY_BITS-1:0]     pressed_now;
  logic [gea_pkg::KEY_BITS-1:0]     released_now;
  logic [gea_pkg::KEY_BITS-1:0]     repeat_pulse;

  modport source (output valid, held_keys, pressed_now, released_now, repeat_pulse,
                  input ready);
  modport sink (input valid, held_keys, pressed_now, released_now, repeat_pulse,
                output ready);
endinterface

### design/gamepad_edge_and_autorepeat.sv
// Channel  Direction  Payload
// in_ch    sink       stick_x, stick_y, hat_angle, hat_centered, button_bits
// out_ch   source     held_keys, pressed_now, released_now, repeat_pulse
// cfg_*    write      cfg_we, cfg_index, cfg_wdata
//
// One frame per cycle while out_ch takes results: a transfer on in_ch updates every key lane in that cycle, and the
// result appears on out_ch in the next cycle from a single output register.
// in_ch stays ready while that register is empty or is being taken in the same cycle.
// Synchronous active-low reset clears every lane's previous held bit, repeat counters and the output valid,
// and restores the register defaults (delay 20, period 5, threshold 500).
module gamepad_edge_and_autorepeat #(
  parameter int BUTTON_COUNT = 16,
  parameter int COUNT_WIDTH  = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gea_in_if.sink                           in_ch,
  gea_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [gea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gea_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int LANE_BUTTONS = (BUTTON_COUNT < gea_pkg::BUTTONS_IN) ?
                                BUTTON_COUNT : gea_pkg::BUTTONS_IN;
  localparam int LANES = gea_pkg::DIR_KEYS + LANE_BUTTONS;

  logic [gea_pkg::DELAY_W-1:0]  first_delay_r;
  logic [gea_pkg::DELAY_W-1:0]  repeat_period_r;
  logic [gea_pkg::THRESH_W-1:0] threshold_r;

  logic                         out_valid_r;
  logic [gea_pkg::KEY_BITS-1:0] held_r;
  logic [gea_pkg::KEY_BITS-1:0] pressed_r;
  logic [gea_pkg::KEY_BITS-1:0] released_r;
  logic [gea_pkg::KEY_BITS-1:0] pulse_r;

  logic                         accept;
  gea_pkg::dir_keys_t           dirs;
  logic [LANES-1:0]             held;
  logic [LANES-1:0]             prev;
  logic [LANES-1:0]             pulse;
  logic [COUNT_WIDTH-1:0]       delay_load;
  logic [COUNT_WIDTH-1:0]       period_load;
  logic [gea_pkg::KEY_BITS-1:0] held_nxt;
  logic [gea_pkg::KEY_BITS-1:0] pressed_nxt;
  logic [gea_pkg::KEY_BITS-1:0] released_nxt;
  logic [gea_pkg::KEY_BITS-1:0] pulse_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r   <= gea_pkg::FIRST_DELAY_RST;
      repeat_period_r <= gea_pkg::REPEAT_PERIOD_RST;
      threshold_r     <= gea_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gea_pkg::CFG_FIRST_DELAY:     first_delay_r   <= cfg_wdata[gea_pkg::DELAY_W-1:0];
        gea_pkg::CFG_REPEAT_PERIOD:   repeat_period_r <= cfg_wdata[gea_pkg::DELAY_W-1:0];
        gea_pkg::CFG_STICK_THRESHOLD: threshold_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign delay_load  = COUNT_WIDTH'(first_delay_r);
  assign period_load = COUNT_WIDTH'(repeat_period_r);

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  gea_dir_decode u_decode (
    .stick_x      (in_ch.stick_x),
    .stick_y      (in_ch.stick_y),
    .hat_angle    (in_ch.hat_angle),
    .hat_centered (in_ch.hat_centered),
    .threshold    (threshold_r),
    .dirs         (dirs)
  );

  assign held[gea_pkg::DIR_KEYS-1:0] = dirs;
  assign held[LANES-1:gea_pkg::DIR_KEYS] = in_ch.button_bits[LANE_BUTTONS-1:0];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    gea_key_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .held        (held[k]),
      .delay_load  (delay_load),
      .period_load (period_load),
      .prev_held   (prev[k]),
      .pulse       (pulse[k])
    );
  end

  // Merge the lanes into the fixed 20-bit result; keys without a lane read as zero.
  assign held_nxt     = gea_pkg::KEY_BITS'(held);
  assign pressed_nxt  = gea_pkg::KEY_BITS'(held & ~prev);
  assign released_nxt = gea_pkg::KEY_BITS'(prev & ~held);
  assign pulse_nxt    = gea_pkg::KEY_BITS'(pulse);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r     <= held_nxt;
      pressed_r  <= pressed_nxt;
      released_r <= released_nxt;
      pulse_r    <= pulse_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.held_keys    = held_r;
  assign out_ch.pressed_now  = pressed_r;
  assign out_ch.released_now = released_r;
  assign out_ch.repeat_pulse = pulse_r;

endmodule

### design/gea_dir_decode.sv
module gea_dir_decode (
  input  logic signed [gea_pkg::AXIS_W-1:0]   stick_x,
  input  logic signed [gea_pkg::AXIS_W-1:0]   stick_y,
  input  logic        [gea_pkg::ANGLE_W-1:0]  hat_angle,
  input  logic                                hat_centered,
  input  logic        [gea_pkg::THRESH_W-1:0] threshold,
  output gea_pkg::dir_keys_t                  dirs
);

  localparam int CMP_W = gea_pkg::THRESH_W + 2;

  logic signed [CMP_W-1:0] x_ext;
  logic signed [CMP_W-1:0] y_ext;
  logic signed [CMP_W-1:0] th_pos;
  logic signed [CMP_W-1:0] th_neg;
  logic                    hat_up;
  logic                    hat_right;
  logic                    hat_down;
  logic                    hat_left;

  assign x_ext  = CMP_W'(stick_x);
  assign y_ext  = CMP_W'(stick_y);
  assign th_pos = $signed({2'b00, threshold});
  assign th_neg = -th_pos;

  // Neighboring sectors share their border angle, so a diagonal holds two keys.
  assign hat_up    = !hat_centered && (hat_angle <= gea_pkg::ANGLE_UP_RIGHT ||
                                       hat_angle >= gea_pkg::ANGLE_LEFT_UP);
  assign hat_right = !hat_centered && hat_angle >= gea_pkg::ANGLE_UP_RIGHT &&
                     hat_angle <= gea_pkg::ANGLE_RIGHT_DOWN;
  assign hat_down  = !hat_centered && hat_angle >= gea_pkg::ANGLE_RIGHT_DOWN &&
                     hat_angle <= gea_pkg::ANGLE_DOWN_LEFT;
  assign hat_left  = !hat_centered && hat_angle >= gea_pkg::ANGLE_DOWN_LEFT &&
                     hat_angle <= gea_pkg::ANGLE_LEFT_UP;

  assign dirs.up    = (y_ext <= th_neg) || hat_up;
  assign dirs.right = (x_ext >= th_pos) || hat_right;
  assign dirs.down  = (y_ext >= th_pos) || hat_down;
  assign dirs.left  = (x_ext <= th_neg) || hat_left;

endmodule

### design/gea_key_lane.sv
module gea_key_lane #(
  parameter int COUNT_WIDTH = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   held,
  input  logic [COUNT_WIDTH-1:0] delay_load,
  input  logic [COUNT_WIDTH-1:0] period_load,
  output logic                   prev_held,
  output logic                   pulse
);

  logic                   prev_r;
  logic                   prev_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign cnt_dec = cnt_r - COUNT_WIDTH'(1);

  always_comb begin
    pulse    = 1'b0;
    cnt_nxt  = '0;
    prev_nxt = held;
    if (held && !prev_r) begin
      pulse   = 1'b1;
      cnt_nxt = delay_load;
    end else if (held) begin
      // A counter of zero wraps here, so a zero load waits a full counter cycle.
      if (cnt_dec == '0) begin
        pulse   = 1'b1;
        cnt_nxt = period_load;
      end else begin
        cnt_nxt = cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign prev_held = prev_r;

endmodule
